// ===== rtl/cst_pkg.sv =====
package cst_pkg;

	localparam int NUM_SEMS_DEF  = 16;
	localparam int NUM_PROCS_DEF = 64;

	localparam int OP_W   = 2;
	localparam int ID_W   = 6;
	localparam int CNT_W  = 16;
	localparam int LINK_W = 7;
	localparam int STAT_W = 2;

	localparam logic [LINK_W-1:0] EMPTY_LINK = 7'd64;
	localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;
	localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7fff;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_WAIT  = 2'd2,
		OP_POST  = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_BAD  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		status_t          status;
		logic [ID_W-1:0]  alloc_id;
		logic             blocked;
		logic             woken_valid;
		logic [ID_W-1:0]  woken_proc;
	} result_t;

	typedef struct packed {
		logic signed [CNT_W-1:0] count;
		logic [LINK_W-1:0]       head;
	} slot_t;

endpackage

// ===== rtl/cst_req_if.sv =====
interface cst_req_if;
	logic                          valid;
	logic                          ready;
	logic [cst_pkg::OP_W-1:0]      operation;
	logic [cst_pkg::ID_W-1:0]      sem_id;
	logic signed [cst_pkg::CNT_W-1:0] init_value;
	logic [cst_pkg::ID_W-1:0]      proc_id;

	modport source (output valid, operation, sem_id, init_value, proc_id, input ready);
	modport sink (input valid, operation, sem_id, init_value, proc_id, output ready);
endinterface

// ===== rtl/cst_rsp_if.sv =====
interface cst_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [cst_pkg::STAT_W-1:0] status;
	logic [cst_pkg::ID_W-1:0]   alloc_id;
	logic                       blocked;
	logic                       woken_valid;
	logic [cst_pkg::ID_W-1:0]   woken_proc;

	modport source (output valid, status, alloc_id, blocked, woken_valid, woken_proc,
		input ready);
	modport sink (input valid, status, alloc_id, blocked, woken_valid, woken_proc,
		output ready);
endinterface

// ===== rtl/counting_semaphore_table.sv =====
// channel  dir  fields
// req      in   operation, sem_id, init_value, proc_id
// rsp      out  status, alloc_id, blocked, woken_valid, woken_proc
//
// One item at a time: allocate, free, wait and a post that wakes nobody pass S_RD
// only; a post that pops a waiter also passes S_LNK (second read, of the link memory).
// The slot memory read is issued on accept; results go to an output register.
// A stalled output holds one finished item; the next item is still taken and waits in S_HOLD.
// Reset clears the in-use flags, the state and the output valid; slot and link memories need no clearing.
module counting_semaphore_table #(
	parameter int NUM_SEMS  = cst_pkg::NUM_SEMS_DEF,
	parameter int NUM_PROCS = cst_pkg::NUM_PROCS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cst_req_if.sink    req,
	cst_rsp_if.source  rsp
);

	localparam int SEM_AW  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int PROC_AW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
	localparam logic [cst_pkg::ID_W:0] SEM_LIM  = (cst_pkg::ID_W+1)'(NUM_SEMS);
	localparam logic [cst_pkg::LINK_W-1:0] PROC_LIM = cst_pkg::LINK_W'(NUM_PROCS);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RD   = 4'b0010,
		S_LNK  = 4'b0100,
		S_HOLD = 4'b1000
	} state_t;

	state_t state_q;

	cst_pkg::op_t                    op_s1;
	logic [cst_pkg::ID_W-1:0]        sid_s1;
	logic signed [cst_pkg::CNT_W-1:0] init_s1;
	logic [cst_pkg::ID_W-1:0]        pid_s1;
	cst_pkg::slot_t                  slot_rd_s1;

	cst_pkg::slot_t                  slot_mem [NUM_SEMS];
	logic [cst_pkg::LINK_W-1:0]      link_mem [NUM_PROCS];
	logic [cst_pkg::LINK_W-1:0]      link_rd_q;

	logic [NUM_SEMS-1:0]             in_use_q;
	logic signed [cst_pkg::CNT_W-1:0] cnt_s2;
	cst_pkg::result_t                res_q;
	cst_pkg::result_t                out_q;
	logic                            out_valid_q;

	logic                            accept;
	logic                            out_free;
	logic                            load_out;
	cst_pkg::result_t                load_res;

	logic                            any_free;
	logic [SEM_AW-1:0]               free_idx;
	logic                            sid_ok;
	logic                            pid_ok;
	logic signed [cst_pkg::CNT_W-1:0] cnt_dec;
	logic signed [cst_pkg::CNT_W-1:0] cnt_inc;
	logic                            wait_blk;
	logic                            need_pop;
	cst_pkg::result_t                res_d;

	logic                            slot_we;
	logic [SEM_AW-1:0]               slot_wa;
	cst_pkg::slot_t                  slot_wd;
	logic                            link_we;
	logic                            link_re;
	logic                            use_set;
	logic                            use_clr;
	logic [cst_pkg::LINK_W-1:0]      nx_head;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || rsp.ready;

	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int i = NUM_SEMS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				any_free = 1'b1;
				free_idx = SEM_AW'(i);
			end
		end
	end

	assign sid_ok  = ({1'b0, sid_s1} < SEM_LIM) && in_use_q[sid_s1[SEM_AW-1:0]];
	assign pid_ok  = ({1'b0, pid_s1} < PROC_LIM);
	assign cnt_dec = (slot_rd_s1.count == cst_pkg::CNT_MIN) ? slot_rd_s1.count
		: slot_rd_s1.count - 16'sd1;
	assign cnt_inc = (slot_rd_s1.count == cst_pkg::CNT_MAX) ? slot_rd_s1.count
		: slot_rd_s1.count + 16'sd1;
	assign wait_blk = cnt_dec[cst_pkg::CNT_W-1];
	assign nx_head  = (link_rd_q < PROC_LIM) ? link_rd_q : cst_pkg::EMPTY_LINK;

	// RD and LNK stages: decide result and the write-backs
	always_comb begin
		res_d    = '0;
		need_pop = 1'b0;
		slot_we  = 1'b0;
		slot_wa  = sid_s1[SEM_AW-1:0];
		slot_wd  = slot_rd_s1;
		link_we  = 1'b0;
		link_re  = 1'b0;
		use_set  = 1'b0;
		use_clr  = 1'b0;
		if (state_q == S_RD) begin
			unique case (op_s1)
				cst_pkg::OP_ALLOC: begin
					if (any_free) begin
						res_d.alloc_id = cst_pkg::ID_W'(free_idx);
						slot_we        = 1'b1;
						slot_wa        = free_idx;
						slot_wd.count  = init_s1;
						slot_wd.head   = cst_pkg::EMPTY_LINK;
						use_set        = 1'b1;
					end else begin
						res_d.status = cst_pkg::ST_FULL;
					end
				end
				cst_pkg::OP_FREE: begin
					if (sid_ok) begin
						use_clr = 1'b1;
					end else begin
						res_d.status = cst_pkg::ST_BAD;
					end
				end
				cst_pkg::OP_WAIT: begin
					if (sid_ok && pid_ok) begin
						slot_we       = 1'b1;
						slot_wd.count = cnt_dec;
						if (wait_blk) begin
							slot_wd.head  = cst_pkg::LINK_W'(pid_s1);
							link_we       = 1'b1;
							res_d.blocked = 1'b1;
						end
					end else begin
						res_d.status = cst_pkg::ST_BAD;
					end
				end
				cst_pkg::OP_POST: begin
					if (sid_ok) begin
						if ((cnt_inc[cst_pkg::CNT_W-1] || cnt_inc == '0)
							&& slot_rd_s1.head < PROC_LIM) begin
							need_pop          = 1'b1;
							link_re           = 1'b1;
							res_d.woken_valid = 1'b1;
							res_d.woken_proc  = slot_rd_s1.head[cst_pkg::ID_W-1:0];
						end else begin
							slot_we       = 1'b1;
							slot_wd.count = cnt_inc;
						end
					end else begin
						res_d.status = cst_pkg::ST_BAD;
					end
				end
			endcase
		end else if (state_q == S_LNK) begin
			slot_we       = 1'b1;
			slot_wd.count = cnt_s2;
			slot_wd.head  = nx_head;
		end
	end

	always_comb begin
		load_out = 1'b0;
		load_res = res_q;
		unique case (state_q)
			S_RD: begin
				load_out = !need_pop && out_free;
				load_res = res_d;
			end
			S_LNK:   load_out = out_free;
			S_HOLD:  load_out = out_free;
			S_IDLE:  load_out = 1'b0;
			default: load_out = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (accept) state_q <= S_RD;
				S_RD: begin
					if (need_pop) state_q <= S_LNK;
					else if (out_free) state_q <= S_IDLE;
					else state_q <= S_HOLD;
				end
				S_LNK:   state_q <= out_free ? S_IDLE : S_HOLD;
				S_HOLD:  if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else if (use_set) begin
			in_use_q[free_idx] <= 1'b1;
		end else if (use_clr) begin
			in_use_q[sid_s1[SEM_AW-1:0]] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= cst_pkg::op_t'(req.operation);
			sid_s1  <= req.sem_id;
			init_s1 <= req.init_value;
			pid_s1  <= req.proc_id;
		end
		if (state_q == S_RD) begin
			res_q  <= res_d;
			cnt_s2 <= cnt_inc;
		end
		if (load_out) begin
			out_q <= load_res;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_wa] <= slot_wd;
		end
		if (accept) begin
			slot_rd_s1 <= slot_mem[req.sem_id[SEM_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[pid_s1[PROC_AW-1:0]] <= slot_rd_s1.head;
		end
		if (link_re) begin
			link_rd_q <= link_mem[slot_rd_s1.head[PROC_AW-1:0]];
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_q.status;
	assign rsp.alloc_id    = out_q.alloc_id;
	assign rsp.blocked     = out_q.blocked;
	assign rsp.woken_valid = out_q.woken_valid;
	assign rsp.woken_proc  = out_q.woken_proc;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_RD)
		else $error("accepted item did not enter read stage");

	assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || rsp.ready))
		else $error("output register overwritten");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.blocked && rsp.woken_valid))
		else $error("item both blocked and woken");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != cst_pkg::ST_OK) |-> !rsp.blocked && !rsp.woken_valid)
		else $error("failed item changed waiters");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int N_SEMS    = cst_pkg::NUM_SEMS_DEF;
	localparam int N_PROCS   = cst_pkg::NUM_PROCS_DEF;
	localparam int MAX_CYCLES = 200000;

	typedef struct packed {
		cst_pkg::op_t                     operation;
		logic [cst_pkg::ID_W-1:0]         sem_id;
		logic signed [cst_pkg::CNT_W-1:0] init_value;
		logic [cst_pkg::ID_W-1:0]         proc_id;
	} sem_req_t;

	logic clk;
	logic arst_n;

	cst_req_if req_ch ();
	cst_rsp_if rsp_ch ();

	counting_semaphore_table DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	sem_req_t          pending_reqs[$];
	cst_pkg::result_t  due_results[$];
	sem_req_t          cur_req;
	int       err_cnt = 0;
	int       n_accepted = 0;
	int       cycles = 0;

	// semaphore table mirror
	logic                             sem_used [N_SEMS];
	logic signed [cst_pkg::CNT_W-1:0] sem_cnt  [N_SEMS];
	logic [cst_pkg::LINK_W-1:0]       sem_head [N_SEMS];
	logic [cst_pkg::LINK_W-1:0]       waiter_link [N_PROCS];

	// allocation shadow for stimulus shaping
	logic gen_used [N_SEMS];

	function automatic cst_pkg::result_t sem_predict(sem_req_t r);
		cst_pkg::result_t           res;
		logic [cst_pkg::LINK_W-1:0] h;
		logic [cst_pkg::LINK_W-1:0] nx;
		res = '0;
		res.status = cst_pkg::ST_OK;
		if (r.operation == cst_pkg::OP_ALLOC) begin
			res.status = cst_pkg::ST_FULL;
			for (int i = 0; i < N_SEMS; i++) begin
				if (!sem_used[i]) begin
					sem_used[i] = 1'b1;
					sem_cnt[i] = r.init_value;
					sem_head[i] = cst_pkg::EMPTY_LINK;
					res.status = cst_pkg::ST_OK;
					res.alloc_id = cst_pkg::ID_W'(i);
					break;
				end
			end
		end else if (r.sem_id >= N_SEMS || !sem_used[r.sem_id]) begin
			res.status = cst_pkg::ST_BAD;
		end else if (r.operation == cst_pkg::OP_FREE) begin
			sem_used[r.sem_id] = 1'b0;
		end else if (r.operation == cst_pkg::OP_WAIT) begin
			if (r.proc_id >= N_PROCS) begin
				res.status = cst_pkg::ST_BAD;
			end else begin
				if (sem_cnt[r.sem_id] != cst_pkg::CNT_MIN)
					sem_cnt[r.sem_id] = sem_cnt[r.sem_id] - 16'sd1;
				if (sem_cnt[r.sem_id] < 0) begin
					waiter_link[r.proc_id] = sem_head[r.sem_id];
					sem_head[r.sem_id] = {1'b0, r.proc_id};
					res.blocked = 1'b1;
				end
			end
		end else begin
			if (sem_cnt[r.sem_id] != cst_pkg::CNT_MAX)
				sem_cnt[r.sem_id] = sem_cnt[r.sem_id] + 16'sd1;
			if (sem_cnt[r.sem_id] <= 0) begin
				h = sem_head[r.sem_id];
				if (h < N_PROCS) begin
					nx = waiter_link[h];
					sem_head[r.sem_id] = (nx < N_PROCS) ? nx : cst_pkg::EMPTY_LINK;
					res.woken_valid = 1'b1;
					res.woken_proc = h[cst_pkg::ID_W-1:0];
				end
			end
		end
		return res;
	endfunction

	function automatic int lowest_free();
		for (int i = 0; i < N_SEMS; i++)
			if (!gen_used[i])
				return i;
		return -1;
	endfunction

	function automatic int pick_used();
		int list[$];
		for (int i = 0; i < N_SEMS; i++)
			if (gen_used[i])
				list.push_back(i);
		if (list.size() == 0)
			return -1;
		return list[$urandom_range(0, list.size() - 1)];
	endfunction

	function automatic logic signed [cst_pkg::CNT_W-1:0] rand_init();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return cst_pkg::CNT_W'($signed($urandom_range(0, 8)) - 4);
		else if (sel == 6)
			return cst_pkg::CNT_W'(cst_pkg::CNT_MAX - $urandom_range(0, 2));
		else if (sel == 7)
			return cst_pkg::CNT_W'(cst_pkg::CNT_MIN + $urandom_range(0, 2));
		return cst_pkg::CNT_W'($urandom);
	endfunction

	function automatic logic signed [cst_pkg::CNT_W-1:0] rand_word();
		return cst_pkg::CNT_W'($urandom);
	endfunction

	task automatic push_item(cst_pkg::op_t op, int sid, logic signed [cst_pkg::CNT_W-1:0] init,
		int pid);
		sem_req_t r;
		int       f;
		r.operation = op;
		r.sem_id = cst_pkg::ID_W'(sid);
		r.init_value = init;
		r.proc_id = cst_pkg::ID_W'(pid);
		if (op == cst_pkg::OP_ALLOC) begin
			f = lowest_free();
			if (f >= 0)
				gen_used[f] = 1'b1;
		end else if (op == cst_pkg::OP_FREE && sid < N_SEMS) begin
			gen_used[sid] = 1'b0;
		end
		pending_reqs.push_back(r);
	endtask

	task automatic gen_random(int n_items);
		int start;
		int kind;
		int s;
		int k;
		int r;
		bit hi;
		start = pending_reqs.size();
		while (pending_reqs.size() - start < n_items) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				r = $urandom_range(0, 99);
				s = pick_used();
				if (s < 0 || $urandom_range(0, 9) >= 8)
					s = $urandom_range(0, 63);
				if (r < 12)
					push_item(cst_pkg::OP_ALLOC, $urandom_range(0, 63), rand_init(),
						$urandom_range(0, 63));
				else if (r < 22)
					push_item(cst_pkg::OP_FREE, s, rand_word(), $urandom_range(0, 63));
				else if (r < 61)
					push_item(cst_pkg::OP_WAIT, s, rand_word(), $urandom_range(0, 63));
				else
					push_item(cst_pkg::OP_POST, s, rand_word(), $urandom_range(0, 63));
			end else if (kind < 60) begin
				s = pick_used();
				if (s < 0) begin
					s = lowest_free();
					push_item(cst_pkg::OP_ALLOC, 0,
						cst_pkg::CNT_W'($signed($urandom_range(0, 4)) - 2), 0);
				end
				k = $urandom_range(1, 8);
				for (int i = 0; i < k; i++)
					push_item(cst_pkg::OP_WAIT, s, rand_word(), $urandom_range(0, 63));
				for (int i = 0; i < k + $urandom_range(0, 1); i++)
					push_item(cst_pkg::OP_POST, s, rand_word(), $urandom_range(0, 63));
			end else if (kind < 70) begin
				while (lowest_free() >= 0)
					push_item(cst_pkg::OP_ALLOC, $urandom_range(0, 63), rand_init(),
						$urandom_range(0, 63));
				push_item(cst_pkg::OP_ALLOC, $urandom_range(0, 63), rand_word(),
					$urandom_range(0, 63));
			end else if (kind < 80) begin
				k = $urandom_range(1, 4);
				for (int i = 0; i < k; i++) begin
					s = pick_used();
					if (s >= 0)
						push_item(cst_pkg::OP_FREE, s, rand_word(), $urandom_range(0, 63));
				end
			end else if (kind < 90) begin
				push_item(cst_pkg::op_t'($urandom_range(0, 3)), $urandom_range(0, 63),
					rand_word(), $urandom_range(0, 63));
			end else begin
				s = lowest_free();
				if (s >= 0) begin
					hi = 1'($urandom_range(0, 1));
					push_item(cst_pkg::OP_ALLOC, 0,
						hi ? cst_pkg::CNT_W'(cst_pkg::CNT_MAX - $urandom_range(0, 2))
							: cst_pkg::CNT_W'(cst_pkg::CNT_MIN + $urandom_range(0, 2)),
						0);
					for (int i = 0; i < 6; i++)
						push_item(($urandom_range(0, 3) == 0) ^ hi ? cst_pkg::OP_POST
							: cst_pkg::OP_WAIT, s, rand_word(), $urandom_range(0, 63));
				end
			end
		end
	endtask

	// sender pauses until every pending item is sent and every result is back
	task automatic drain();
		do
			@(negedge clk);
		while (pending_reqs.size() > 0 || req_ch.valid || due_results.size() > 0);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver: bursts of items with random gaps
	int burst_left = 4;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.operation <= '0;
			req_ch.sem_id <= '0;
			req_ch.init_value <= '0;
			req_ch.proc_id <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				due_results.push_back(sem_predict(cur_req));
				n_accepted <= n_accepted + 1;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					cur_req = pending_reqs.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.operation <= cur_req.operation;
					req_ch.sem_id <= cur_req.sem_id;
					req_ch.init_value <= cur_req.init_value;
					req_ch.proc_id <= cur_req.proc_id;
					burst_left--;
					if (burst_left <= 0) begin
						if ($urandom_range(0, 4) == 0) begin
							burst_left = $urandom_range(30, 60);
							gap_left = 0;
						end else begin
							burst_left = $urandom_range(1, 20);
							gap_left = $urandom_range(1, 6);
						end
					end
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, once, while the sender keeps going
	int  hold_left = 0;
	bit  hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && n_accepted >= 200) begin
			hold_left <= 400;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor: receiver stall pattern and result check
	int rx_mode = 0;
	int rx_phase = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (due_results.size() == 0) begin
					$error("unexpected item: status %0d", rsp_ch.status);
					err_cnt++;
				end else begin
					cst_pkg::result_t want;
					want = due_results.pop_front();
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
						err_cnt++;
					end
					if (rsp_ch.alloc_id !== want.alloc_id) begin
						$error("alloc_id: expected %0d, got %0d", want.alloc_id, rsp_ch.alloc_id);
						err_cnt++;
					end
					if (rsp_ch.blocked !== want.blocked) begin
						$error("blocked: expected %0d, got %0d", want.blocked, rsp_ch.blocked);
						err_cnt++;
					end
					if (rsp_ch.woken_valid !== want.woken_valid) begin
						$error("woken_valid: expected %0d, got %0d", want.woken_valid,
							rsp_ch.woken_valid);
						err_cnt++;
					end
					if (rsp_ch.woken_proc !== want.woken_proc) begin
						$error("woken_proc: expected %0d, got %0d", want.woken_proc,
							rsp_ch.woken_proc);
						err_cnt++;
					end
				end
			end
			rx_phase++;
			if (rx_phase >= 64) begin
				rx_phase = 0;
				rx_mode = $urandom_range(0, 3);
			end
			if (hold_left > 0)
				rsp_ch.ready <= 1'b0;
			else case (rx_mode)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= 1'($urandom_range(0, 1));
				2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				default: rsp_ch.ready <= rx_phase[0];
			endcase
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == MAX_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		for (int i = 0; i < N_SEMS; i++) begin
			sem_used[i] = 1'b0;
			sem_cnt[i] = '0;
			sem_head[i] = cst_pkg::EMPTY_LINK;
			gen_used[i] = 1'b0;
		end
		for (int i = 0; i < N_PROCS; i++)
			waiter_link[i] = '0;

		push_item(cst_pkg::OP_ALLOC, 0, cst_pkg::CNT_MAX, 0);
		push_item(cst_pkg::OP_ALLOC, 0, cst_pkg::CNT_MIN, 0);
		push_item(cst_pkg::OP_ALLOC, 0, 0, 0);
		push_item(cst_pkg::OP_ALLOC, 0, -3, 0);
		push_item(cst_pkg::OP_POST, 0, 0, 0);
		push_item(cst_pkg::OP_WAIT, 1, 0, 63);
		push_item(cst_pkg::OP_WAIT, 2, 0, 0);
		push_item(cst_pkg::OP_WAIT, 2, 0, 5);
		push_item(cst_pkg::OP_WAIT, 2, 0, 5);
		push_item(cst_pkg::OP_POST, 2, 0, 0);
		push_item(cst_pkg::OP_POST, 2, 0, 0);
		push_item(cst_pkg::OP_POST, 3, 0, 0);
		push_item(cst_pkg::OP_FREE, 1, 0, 0);
		push_item(cst_pkg::OP_WAIT, 1, 0, 9);
		push_item(cst_pkg::OP_POST, 63, 16'sh7fff, 63);
		push_item(cst_pkg::OP_FREE, N_SEMS, 0, 0);
		push_item(cst_pkg::OP_ALLOC, 0, 16'sh5555, 0);
		push_item(cst_pkg::OP_POST, 1, 0, 0);
		push_item(cst_pkg::OP_WAIT, 0, 16'shaaaa, 42);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		drain();
		gen_random(650);
		drain();
		gen_random(650);
		drain();
		repeat (20) @(posedge clk);
		if (err_cnt == 0 && due_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
